/* design/sqrtok_pkg.sv */
// ----------------------------------------------------------------------------
// sqrtok_pkg
// Shared types, codes and scan tables for the shell quote removal tokenizer.
// ----------------------------------------------------------------------------
package sqrtok_pkg;

  // argument count limit and its 8-bit saturation cap
  localparam int unsigned MaxArgs = 255;
  localparam logic [7:0]  ArgCap  = (MaxArgs > 255) ? 8'd255 : 8'(MaxArgs);

  // byte classes
  localparam logic [2:0] CLS_SQUOTE = 3'd0;
  localparam logic [2:0] CLS_DQUOTE = 3'd1;
  localparam logic [2:0] CLS_BSLASH = 3'd2;
  localparam logic [2:0] CLS_BLANK  = 3'd3;
  localparam logic [2:0] CLS_OTHER  = 3'd4;
  localparam logic [2:0] CLS_END    = 3'd5;

  // scan states
  localparam logic [2:0] ST_SKIP    = 3'd0;
  localparam logic [2:0] ST_WORD    = 3'd1;
  localparam logic [2:0] ST_ESC     = 3'd2;
  localparam logic [2:0] ST_SQUOTE  = 3'd3;
  localparam logic [2:0] ST_DQUOTE  = 3'd4;
  localparam logic [2:0] ST_DQ_ESC  = 3'd5;

  // next-state codes that end the line
  localparam logic [3:0] NX_DONE    = 4'd6;
  localparam logic [3:0] NX_PREMAT  = 4'd7;
  localparam logic [3:0] NX_NO_SQ   = 4'd8;
  localparam logic [3:0] NX_NO_DQ   = 4'd9;

  // actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_KEEP   = 2'd1;
  localparam logic [1:0] ACT_ENDARG = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_ARG   = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;

  // special bytes
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;

  // next state per state (row) and class (column)
  localparam logic [3:0] NEXT_TAB [6][6] = '{
    '{4'd3, 4'd4, 4'd2, 4'd0, 4'd1, 4'd6},
    '{4'd3, 4'd4, 4'd2, 4'd0, 4'd1, 4'd6},
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7},
    '{4'd1, 4'd3, 4'd3, 4'd3, 4'd3, 4'd8},
    '{4'd4, 4'd1, 4'd5, 4'd4, 4'd4, 4'd9},
    '{4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd7}
  };

  // action per state (row) and class (column)
  localparam logic [1:0] ACT_TAB [6][6] = '{
    '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 2'd0},
    '{2'd0, 2'd0, 2'd0, 2'd2, 2'd1, 2'd2},
    '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0},
    '{2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd0, 2'd0, 2'd1, 2'd1, 2'd0},
    '{2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd0}
  };

  // one result transaction
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [7:0] arg_total;
    logic [1:0] error_code;
    logic       last;
  } res_t;

  // everything one byte produces
  typedef struct packed {
    res_t       res0;
    res_t       res1;
    logic [1:0] res_cnt;
    logic [2:0] state_nxt;
    logic [7:0] count_nxt;
  } step_t;

  // byte classifier
  function automatic logic [2:0] classify(input logic [7:0] b);
    logic [2:0] c;
    if (b == CH_NUL)                          c = CLS_END;
    else if (b == CH_SQUOTE)                  c = CLS_SQUOTE;
    else if (b == CH_DQUOTE)                  c = CLS_DQUOTE;
    else if (b == CH_BSLASH)                  c = CLS_BSLASH;
    else if (b == CH_SPACE || b == CH_TAB)    c = CLS_BLANK;
    else                                      c = CLS_OTHER;
    return c;
  endfunction

endpackage

/* design/sqrtok_step.sv */
// ----------------------------------------------------------------------------
// sqrtok_step
// Combinational scan step: classifies one byte, looks up the quoting tables
// and forms up to two results plus the next scan state and argument count.
// ----------------------------------------------------------------------------
module sqrtok_step (
  input  logic [7:0]         text_byte_i,
  input  logic [2:0]         state_i,
  input  logic [7:0]         count_i,
  output sqrtok_pkg::step_t  step_o
);
  import sqrtok_pkg::*;

  logic [2:0] cls;
  logic [2:0] st;
  logic [1:0] act;
  logic [3:0] nxt;
  logic [7:0] count_inc;
  logic       line_end;
  res_t       act_res;
  res_t       end_res;

  // table lookup, unused state codes behave as whitespace skip
  always_comb begin
    cls = classify(text_byte_i);
    st  = (state_i > ST_DQ_ESC) ? ST_SKIP : state_i;
    act = ACT_TAB[st][cls];
    nxt = NEXT_TAB[st][cls];
  end

  // saturating argument count after an argument end
  assign count_inc = (act == ACT_ENDARG && count_i < ArgCap) ? count_i + 8'd1 : count_i;
  assign line_end  = (nxt >= NX_DONE);

  // result from the action
  always_comb begin
    act_res            = '0;
    act_res.arg_total  = count_inc;
    act_res.error_code = ERR_NONE;
    act_res.last       = ~line_end;
    if (act == ACT_KEEP) begin
      act_res.kind     = KIND_CHAR;
      act_res.out_byte = text_byte_i;
    end else begin
      act_res.kind     = KIND_ARG;
      act_res.out_byte = 8'h00;
    end
  end

  // result from the end of the line
  always_comb begin
    end_res            = '0;
    end_res.arg_total  = count_inc;
    end_res.out_byte   = 8'h00;
    end_res.last       = 1'b1;
    if (nxt == NX_DONE) begin
      end_res.kind       = KIND_DONE;
      end_res.error_code = ERR_NONE;
    end else begin
      end_res.kind       = KIND_ERR;
      end_res.error_code = 2'(nxt - NX_DONE);
    end
  end

  // pack results in order
  always_comb begin
    step_o = '0;
    if (act != ACT_NONE) begin
      step_o.res0    = act_res;
      step_o.res1    = end_res;
      step_o.res_cnt = line_end ? 2'd2 : 2'd1;
    end else begin
      step_o.res0    = end_res;
      step_o.res1    = end_res;
      step_o.res_cnt = line_end ? 2'd1 : 2'd0;
    end
    step_o.state_nxt = line_end ? ST_SKIP : nxt[2:0];
    step_o.count_nxt = line_end ? 8'd0 : count_inc;
  end

endmodule

/* design/shell_quote_removal_tokenizer.sv */
// ----------------------------------------------------------------------------
// shell_quote_removal_tokenizer
// Splits a zero-terminated command line into arguments, removing one level
// of shell quoting and escaping.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the queue has room; its scan step completes
// in that cycle and its results are registered into a three-entry result queue
// that drains one transaction per cycle while the output is ready. A byte that
// ends an unquoted word at end of line produces two results, so sustained input
// is one byte per cycle as long as the output is ready and each byte yields at
// most one result; the queue drain port, one result per cycle, sets the rate
// otherwise. Input is accepted whenever the queue holds at most one result.
module shell_quote_removal_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [7:0] arg_total_o,
  output logic [1:0] error_code_o,
  output logic       last_o
);
  import sqrtok_pkg::*;

  logic [2:0] state_q, state_d;
  logic [7:0] count_q, count_d;
  logic [1:0] fill_q, fill_d;
  res_t       queue_q [3];
  res_t       queue_d [3];
  step_t      step;
  logic       in_acc;
  logic       pop;
  logic [1:0] keep;
  logic [1:0] push;
  logic [1:0] slot_off;

  // scan step
  sqrtok_step u_step (
    .text_byte_i (text_byte_i),
    .state_i     (state_q),
    .count_i     (count_q),
    .step_o      (step)
  );

  // handshakes
  assign in_ready_o  = (fill_q <= 2'd1);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_valid_o = (fill_q != 2'd0);
  assign pop         = out_valid_o & out_ready_i;
  assign keep        = fill_q - {1'b0, pop};
  assign push        = in_acc ? step.res_cnt : 2'd0;
  assign fill_d      = keep + push;

  // scan state update
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    if (in_acc) begin
      state_d = step.state_nxt;
      count_d = step.count_nxt;
    end
  end

  // result queue: shift on pop, append new results behind the kept ones
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      slot_off   = 2'(i) - keep;
      queue_d[i] = queue_q[i];
      if (2'(i) < keep) begin
        if (pop && i < 2) queue_d[i] = queue_q[(i < 2) ? i + 1 : i];
      end else if (slot_off == 2'd0 && push >= 2'd1) begin
        queue_d[i] = step.res0;
      end else if (slot_off == 2'd1 && push == 2'd2) begin
        queue_d[i] = step.res1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_SKIP;
      count_q <= 8'd0;
      fill_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      fill_q  <= fill_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    queue_q <= queue_d;
  end

  // head of queue drives the output
  assign kind_o       = queue_q[0].kind;
  assign out_byte_o   = queue_q[0].out_byte;
  assign arg_total_o  = queue_q[0].arg_total;
  assign error_code_o = queue_q[0].error_code;
  assign last_o       = queue_q[0].last;

  // queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> ({1'b0, keep} + {1'b0, push}) <= 3'd3)
    else $error("accepted byte left no room accounting in result queue");

  // line end results always close their byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_DONE || kind_o == KIND_ERR) |-> last_o)
    else $error("line end result not marked last");

  // error code only on syntax error
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_ERR |-> error_code_o == ERR_NONE)
    else $error("error code set on a non-error result");

  // line end clears the scan state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && text_byte_i == CH_NUL |=> state_q == ST_SKIP && count_q == 8'd0)
    else $error("scan state not cleared at end of line");

  // argument count never passes the cap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ArgCap)
    else $error("argument count above cap");

endmodule

/* bench/tb_shell_quote_removal_tokenizer.sv */
// ----------------------------------------------------------------------------
// tb_shell_quote_removal_tokenizer
// Self-checking bench for the shell quote removal tokenizer. Command lines
// (directed corner cases, then random well-formed, truncated and noisy
// lines) are streamed in. A scoreboard predicts every token, argument end,
// done and error transaction and compares them with the output stream. Both
// handshakes see random stalls.
// ----------------------------------------------------------------------------
module tb_shell_quote_removal_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import sqrtok_pkg::*;

  // error codes beyond "none"
  localparam logic [1:0] ERR_PREMATURE = 2'd1;
  localparam logic [1:0] ERR_NO_SQ     = 2'd2;
  localparam logic [1:0] ERR_NO_DQ     = 2'd3;

  localparam int unsigned RandomItems = 1750;
  localparam int unsigned SatArgs     = 258;

  // --------------------------------------------------------------------------
  // token scoreboard: tracks the scan state and argument count of the line
  // and keeps the tokens the block still owes
  // --------------------------------------------------------------------------
  class arg_splitter_scoreboard;
    res_t        expected_tokens[$];
    logic [2:0]  scan_st;
    logic [7:0]  arg_cnt;
    int unsigned errors;

    function new();
      scan_st = ST_SKIP;
      arg_cnt = 8'd0;
      errors  = 0;
    endfunction

    function automatic logic [2:0] byte_class(logic [7:0] b);
      case (b)
        CH_NUL:          return CLS_END;
        CH_SQUOTE:       return CLS_SQUOTE;
        CH_DQUOTE:       return CLS_DQUOTE;
        CH_BSLASH:       return CLS_BSLASH;
        CH_SPACE, CH_TAB: return CLS_BLANK;
        default:         return CLS_OTHER;
      endcase
    endfunction

    // one accepted byte: advance the scan and queue the tokens it causes
    function void note_byte(logic [7:0] b);
      logic [2:0] cls;
      logic [2:0] st;
      logic [2:0] nxt;
      logic [1:0] act;
      logic [1:0] err;
      res_t       tok [2];
      int         n;
      cls = byte_class(b);
      st  = (scan_st > ST_DQ_ESC) ? ST_SKIP : scan_st;
      act = ACT_NONE;
      err = ERR_NONE;
      n   = 0;
      case (st)
        ST_SKIP, ST_WORD: begin
          case (cls)
            CLS_SQUOTE: nxt = ST_SQUOTE;
            CLS_DQUOTE: nxt = ST_DQUOTE;
            CLS_BSLASH: nxt = ST_ESC;
            CLS_OTHER:  nxt = ST_WORD;
            default:    nxt = ST_SKIP;
          endcase
          if (cls == CLS_OTHER) act = ACT_KEEP;
          else if (st == ST_WORD && (cls == CLS_BLANK || cls == CLS_END)) act = ACT_ENDARG;
        end
        ST_ESC: begin
          nxt = ST_WORD;
          err = ERR_PREMATURE;
          if (cls != CLS_END) act = ACT_KEEP;
        end
        ST_SQUOTE: begin
          nxt = (cls == CLS_SQUOTE) ? ST_WORD : ST_SQUOTE;
          err = ERR_NO_SQ;
          if (cls != CLS_SQUOTE && cls != CLS_END) act = ACT_KEEP;
        end
        ST_DQUOTE: begin
          nxt = (cls == CLS_DQUOTE) ? ST_WORD : (cls == CLS_BSLASH) ? ST_DQ_ESC : ST_DQUOTE;
          err = ERR_NO_DQ;
          if (cls != CLS_DQUOTE && cls != CLS_BSLASH && cls != CLS_END) act = ACT_KEEP;
        end
        default: begin
          // escaped byte inside double quotes goes back to double-quote mode
          nxt = ST_DQUOTE;
          err = ERR_PREMATURE;
          if (cls != CLS_END) act = ACT_KEEP;
        end
      endcase

      // kept character or argument end
      if (act == ACT_KEEP) begin
        tok[n] = '0;
        tok[n].kind = KIND_CHAR;
        tok[n].out_byte = b;
        tok[n].arg_total = arg_cnt;
        n++;
      end else if (act == ACT_ENDARG) begin
        if (arg_cnt < ArgCap) arg_cnt++;
        tok[n] = '0;
        tok[n].kind = KIND_ARG;
        tok[n].arg_total = arg_cnt;
        n++;
      end

      // end of line: done or syntax error, then clear for the next line
      if (cls == CLS_END) begin
        tok[n] = '0;
        tok[n].kind = (err == ERR_NONE) ? KIND_DONE : KIND_ERR;
        tok[n].arg_total = arg_cnt;
        tok[n].error_code = err;
        n++;
        scan_st = ST_SKIP;
        arg_cnt = 8'd0;
      end else begin
        scan_st = nxt;
      end

      if (n > 0) tok[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_tokens.push_back(tok[i]);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // one accepted output transaction against the oldest prediction
    function void check_token(res_t got);
      res_t want;
      if (expected_tokens.size() == 0) begin
        $display("%0t ns: unexpected transaction, expected none, actual kind %0d byte %0d",
                 $time, got.kind, got.out_byte);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      cmp_field("kind", 8'(want.kind), 8'(got.kind));
      cmp_field("out_byte", want.out_byte, got.out_byte);
      cmp_field("arg_total", want.arg_total, got.arg_total);
      cmp_field("error_code", 8'(want.error_code), 8'(got.error_code));
      cmp_field("last", 8'(want.last), 8'(got.last));
    endfunction

    function int unsigned outstanding();
      return expected_tokens.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals and block
  // --------------------------------------------------------------------------
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] text_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b1;
  logic [1:0] kind_o;
  logic [7:0] out_byte_o;
  logic [7:0] arg_total_o;
  logic [1:0] error_code_o;
  logic       last_o;

  arg_splitter_scoreboard sb = new();

  bit          calm_in  = 1'b0;
  bit          calm_out = 1'b0;
  int unsigned n_sent   = 0;
  logic [7:0]  line_buf[$];

  shell_quote_removal_tokenizer u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .text_byte_i  (text_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .out_byte_o   (out_byte_o),
    .arg_total_o  (arg_total_o),
    .error_code_o (error_code_o),
    .last_o       (last_o)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // directed lines: blanks and extreme bytes, empty quotes, every error path
  localparam logic [7:0] DIRECTED [27] = '{
    CH_TAB, 8'h61, 8'hFF, CH_SPACE, 8'h01, CH_NUL,
    CH_SQUOTE, CH_SQUOTE, CH_SPACE, CH_DQUOTE, CH_DQUOTE, CH_NUL,
    CH_BSLASH, CH_NUL,
    CH_SQUOTE, CH_BSLASH, CH_DQUOTE, CH_NUL,
    CH_DQUOTE, CH_SQUOTE, CH_BSLASH, CH_BSLASH, CH_NUL,
    CH_DQUOTE, CH_BSLASH, CH_NUL,
    CH_NUL
  };

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  // one input transaction, with a random gap before it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = calm_in ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_byte(b);
    n_sent++;
  endtask

  // hold the sender off until the block has delivered everything
  task automatic drain_pause();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_SQUOTE || b == CH_DQUOTE || b == CH_BSLASH || b == CH_SPACE || b == CH_TAB);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  // well-formed line of quoted, escaped and plain words, ended by a zero byte
  function automatic void build_line();
    int unsigned nwords;
    int unsigned nseg;
    int unsigned nch;
    logic [7:0]  b;
    line_buf.delete();
    if ($urandom_range(0, 3) == 0) line_buf.push_back(blank_byte());
    nwords = $urandom_range(0, 5);
    for (int w = 0; w < nwords; w++) begin
      nseg = $urandom_range(1, 3);
      for (int s = 0; s < nseg; s++) begin
        nch = $urandom_range(0, 3);
        case ($urandom_range(0, 3))
          0: begin
            for (int c = 0; c <= nch; c++) line_buf.push_back(plain_byte());
          end
          1: begin
            line_buf.push_back(CH_BSLASH);
            line_buf.push_back(8'($urandom_range(1, 255)));
          end
          2: begin
            line_buf.push_back(CH_SQUOTE);
            for (int c = 0; c < nch; c++) begin
              do b = 8'($urandom_range(1, 255)); while (b == CH_SQUOTE);
              line_buf.push_back(b);
            end
            line_buf.push_back(CH_SQUOTE);
          end
          default: begin
            line_buf.push_back(CH_DQUOTE);
            for (int c = 0; c < nch; c++) begin
              if ($urandom_range(0, 3) == 0) begin
                line_buf.push_back(CH_BSLASH);
                line_buf.push_back(8'($urandom_range(1, 255)));
              end else begin
                do b = 8'($urandom_range(1, 255)); while (b == CH_DQUOTE || b == CH_BSLASH);
                line_buf.push_back(b);
              end
            end
            line_buf.push_back(CH_DQUOTE);
          end
        endcase
      end
      if (w + 1 < nwords || $urandom_range(0, 3) == 0) begin
        line_buf.push_back(blank_byte());
        if ($urandom_range(0, 2) == 0) line_buf.push_back(blank_byte());
      end
    end
    line_buf.push_back(CH_NUL);
  endfunction

  // random bytes rich in quote, escape and blank characters
  function automatic void build_noise();
    int unsigned n;
    line_buf.delete();
    n = $urandom_range(1, 12);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 6))
        0:       line_buf.push_back(CH_SQUOTE);
        1:       line_buf.push_back(CH_DQUOTE);
        2:       line_buf.push_back(CH_BSLASH);
        3:       line_buf.push_back(blank_byte());
        default: line_buf.push_back(8'($urandom_range(1, 255)));
      endcase
    end
    line_buf.push_back(CH_NUL);
  endfunction

  // --------------------------------------------------------------------------
  // output side: random ready stalls per transaction, scoreboard check
  // --------------------------------------------------------------------------
  initial begin
    int unsigned hold;
    res_t        got;
    hold = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.kind       = kind_o;
        got.out_byte   = out_byte_o;
        got.arg_total  = arg_total_o;
        got.error_code = error_code_o;
        got.last       = last_o;
        sb.check_token(got);
        if ($urandom_range(0, 31) == 0) calm_out = ~calm_out;
        hold = calm_out ? 0 : $urandom_range(0, 3);
        if (hold > 0) out_ready_i <= 1'b0;
      end else if (!out_ready_i) begin
        if (hold > 0) hold--;
        if (hold == 0) out_ready_i <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned sat_at;
    int unsigned cut;
    // reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed corner cases
    foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
    drain_pause();

    // random lines, with one long line that saturates the argument count
    sat_at = $urandom_range(200, 800);
    while (n_sent < RandomItems) begin
      if ($urandom_range(0, 7) == 0) calm_in = ~calm_in;
      if (sat_at != 0 && n_sent >= sat_at) begin
        sat_at = 0;
        line_buf.delete();
        for (int i = 0; i < SatArgs; i++) begin
          line_buf.push_back(plain_byte());
          line_buf.push_back(blank_byte());
        end
        line_buf.push_back(CH_NUL);
      end else begin
        case ($urandom_range(0, 9))
          0, 1: build_noise();
          2, 3: begin
            // well-formed line cut short anywhere
            build_line();
            cut = $urandom_range(0, line_buf.size() - 1);
            while (line_buf.size() > cut) void'(line_buf.pop_back());
            line_buf.push_back(CH_NUL);
          end
          default: build_line();
        endcase
      end
      send_line();
      if ($urandom_range(0, 19) == 0) drain_pause();
    end

    // wait for the last transactions, then let the block idle
    in_valid_i <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("tb_shell_quote_removal_tokenizer: PASS");
    end else begin
      $display("tb_shell_quote_removal_tokenizer: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2ms;
    $display("%0t ns: timeout with %0d transactions outstanding", $time, sb.outstanding());
    $display("tb_shell_quote_removal_tokenizer: FAIL");
    $finish;
  end

endmodule
